// ----- rtl/core/wrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared command codes and the queue entry type of the task scheduler.
// ----------------------------------------------------------------------------
package wrr_pkg;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_EXIT   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam int unsigned PrioW = 8;
  localparam int unsigned IdW   = 16;
  localparam int unsigned OutSlotW = 7;

  typedef struct packed {
    cmd_e             cmd;
    logic [PrioW-1:0] prio;
  } req_t;

endpackage

// ----- rtl/core/wrr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_front
// Input stage: registers and classifies a command into a two-entry queue.
// ----------------------------------------------------------------------------
module wrr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        priority_req_i,
  output logic              q_valid_o,
  output wrr_pkg::req_t     q_data_o,
  input  logic              q_pop_i
);

  wrr_pkg::req_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: wrr_pkg::cmd_e'(command_i), prio: priority_req_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");

endmodule

// ----- rtl/core/wrr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_back
// Execution engine: slot table, serial slot searches and result register.
// ----------------------------------------------------------------------------
module wrr_back #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  wrr_pkg::req_t     q_data_i,
  output logic              q_pop_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [15:0]       created_id_o,
  output logic [6:0]        created_slot_o,
  output logic              table_full_o,
  output logic [6:0]        run_slot_o,
  output logic              run_valid_o,
  output logic              switched_o,
  output logic              first_start_o,
  output logic              halted_o
);

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned SlotW = wrr_pkg::OutSlotW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q;

  // occupancy bits (task id nonzero) live in flops; other fields in memory
  logic [SLOT_COUNT-1:0] occ_q;
  logic [7:0]  prio_mem [SLOT_COUNT];
  logic [7:0]  slice_mem [SLOT_COUNT];
  logic        start_mem [SLOT_COUNT];

  logic [SW-1:0] cur_q;
  logic          cur_valid_q, halt_q;
  logic [15:0]   next_id_q;
  wrr_pkg::req_t req_q;

  logic [CW-1:0] step_q;     // scan position counter
  logic [SW-1:0] hit_q;
  logic          found_q;

  logic [7:0] rd_prio_q, rd_slice_q;
  logic       rd_start_q;

  logic [SW-1:0] scan_idx;
  logic [CW-1:0] scan_sum;
  logic          scan_done;

  always_comb begin
    if (req_q.cmd == wrr_pkg::CMD_CREATE || !cur_valid_q) begin
      scan_sum = step_q;
    end else begin
      scan_sum = {1'b0, cur_q} + step_q;
      if (scan_sum >= CW'(SLOT_COUNT)) scan_sum = scan_sum - CW'(SLOT_COUNT);
    end
    scan_idx = scan_sum[SW-1:0];
  end

  // one slot per cycle; the test differs for create (free) and tick (occupied)
  logic scan_hit;
  assign scan_hit = (req_q.cmd == wrr_pkg::CMD_CREATE) ? !occ_q[scan_idx] : occ_q[scan_idx];
  assign scan_done = scan_hit || (step_q == CW'(SLOT_COUNT - 1)) ||
                     (req_q.cmd == wrr_pkg::CMD_CREATE && step_q == CW'(SLOT_COUNT - 1));

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // registered reads of the current slot (priority, slice) and of the hit slot (start flag)
  always_ff @(posedge clk_i) begin
    rd_prio_q  <= prio_mem[cur_q];
    rd_slice_q <= slice_mem[cur_q];
    rd_start_q <= start_mem[hit_q];
  end

  logic tick_scan_start;
  assign tick_scan_start = (req_q.cmd == wrr_pkg::CMD_TICK);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      case (req_q.cmd)
        wrr_pkg::CMD_CREATE: begin
          if (found_q) begin
            prio_mem[hit_q]  <= req_q.prio;
            slice_mem[hit_q] <= req_q.prio;
            start_mem[hit_q] <= 1'b0;
          end
        end
        wrr_pkg::CMD_TICK: begin
          if (!halt_q) begin
            if (cur_valid_q && rd_slice_q != 8'd0) begin
              slice_mem[cur_q] <= rd_slice_q - 8'd1;
            end else if (found_q) begin
              if (cur_valid_q) slice_mem[cur_q] <= rd_prio_q;
              start_mem[hit_q] <= 1'b1;
            end
          end
        end
        wrr_pkg::CMD_EXIT: begin
          if (cur_valid_q && !halt_q) slice_mem[cur_q] <= 8'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      occ_q         <= '0;
      cur_q         <= '0;
      cur_valid_q   <= 1'b0;
      halt_q        <= 1'b0;
      next_id_q     <= 16'd1;
      req_q         <= '{cmd: wrr_pkg::CMD_NOP, prio: '0};
      step_q        <= '0;
      hit_q         <= '0;
      found_q       <= 1'b0;
      valid_o       <= 1'b0;
      created_id_o  <= '0;
      created_slot_o <= '0;
      table_full_o  <= 1'b0;
      run_slot_o    <= '0;
      run_valid_o   <= 1'b0;
      switched_o    <= 1'b0;
      first_start_o <= 1'b0;
      halted_o      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            req_q   <= q_data_i;
            found_q <= 1'b0;
            hit_q   <= '0;
            // a tick with a current task scans from the slot after it
            step_q  <= (q_data_i.cmd == wrr_pkg::CMD_TICK && cur_valid_q) ? CW'(1) : '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (req_q.cmd != wrr_pkg::CMD_CREATE && !tick_scan_start) begin
            state_q <= ST_READ;
          end else if (tick_scan_start && cur_valid_q && step_q == '0) begin
            state_q <= ST_READ;
          end else begin
            if (scan_hit) begin
              found_q <= 1'b1;
              hit_q   <= scan_idx;
            end
            if (scan_done || (cur_valid_q && tick_scan_start &&
                              step_q >= CW'(SLOT_COUNT - 1))) begin
              state_q <= ST_READ;
            end else begin
              step_q <= step_q + CW'(1);
            end
          end
        end
        ST_READ: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          created_id_o   <= '0;
          created_slot_o <= '0;
          table_full_o   <= 1'b0;
          switched_o     <= 1'b0;
          first_start_o  <= 1'b0;
          case (req_q.cmd)
            wrr_pkg::CMD_CREATE: begin
              if (found_q) begin
                occ_q[hit_q]   <= 1'b1;
                created_id_o   <= next_id_q;
                created_slot_o <= SlotW'(hit_q);
                next_id_q      <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
              end else begin
                table_full_o <= 1'b1;
              end
            end
            wrr_pkg::CMD_TICK: begin
              if (!halt_q && !(cur_valid_q && rd_slice_q != 8'd0)) begin
                if (found_q) begin
                  switched_o    <= 1'b1;
                  first_start_o <= !rd_start_q;
                  cur_q         <= hit_q;
                  cur_valid_q   <= 1'b1;
                end else if (!cur_valid_q || !occ_q[cur_q]) begin
                  halt_q <= 1'b1;
                end
              end
            end
            wrr_pkg::CMD_EXIT: begin
              if (cur_valid_q && !halt_q) occ_q[cur_q] <= 1'b0;
            end
            default: ;
          endcase
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!valid_o) begin
            run_valid_o <= cur_valid_q && !halt_q && occ_q[cur_q];
            run_slot_o  <= (cur_valid_q && !halt_q && occ_q[cur_q]) ? SlotW'(cur_q) : '0;
            halted_o    <= halt_q;
            valid_o     <= 1'b1;
          end else if (!stall_i) begin
            valid_o <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> state_q == ST_OUT)
    else $error("result valid outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(halt_q) |=> halt_q)
    else $error("halt flag cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_valid_o |-> !halted_o)
    else $error("running while halted");

endmodule

// ----- rtl/core/weighted_round_robin_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_task_scheduler
// Time-slice task scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Each command yields exactly one result. It passes through the scan, read,
// execute and output states; a create and every tick search the occupancy bits
// serially, one slot per cycle, visiting up to SLOT_COUNT slots. A two-entry
// command queue keeps accepting input while the engine works or its result is
// stalled, until it holds two entries.
module weighted_round_robin_task_scheduler #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  priority_req_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] created_id_o,
  output logic [6:0]  created_slot_o,
  output logic        table_full_o,
  output logic [6:0]  run_slot_o,
  output logic        run_valid_o,
  output logic        switched_o,
  output logic        first_start_o,
  output logic        halted_o
);

  logic          q_valid, q_pop;
  wrr_pkg::req_t q_data;

  wrr_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .priority_req_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  wrr_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .valid_o, .stall_i, .created_id_o, .created_slot_o, .table_full_o,
    .run_slot_o, .run_valid_o, .switched_o, .first_start_o, .halted_o
  );

endmodule

// ----- tb/sv/wrr_sched_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_sched_checker
// Watches both channels of the task scheduler, predicts each result from its
// own copy of the slot table and compares the results field by field.
// ----------------------------------------------------------------------------
module wrr_sched_checker #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  priority_req_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [15:0] created_id_o,
  input  logic [6:0]  created_slot_o,
  input  logic        table_full_o,
  input  logic [6:0]  run_slot_o,
  input  logic        run_valid_o,
  input  logic        switched_o,
  input  logic        first_start_o,
  input  logic        halted_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          switch_count_o,
  output int          full_count_o,
  output int          halt_seen_o,
  output int          occupied_o
);

  typedef struct packed {
    logic [15:0] created_id;
    logic [6:0]  created_slot;
    logic        table_full;
    logic [6:0]  run_slot;
    logic        run_valid;
    logic        switched;
    logic        first_start;
    logic        halted;
  } sched_result_t;

  logic [15:0] task_id [SLOT_COUNT];
  logic [7:0]  task_prio [SLOT_COUNT];
  logic [7:0]  slice_left [SLOT_COUNT];
  logic        started [SLOT_COUNT];
  int unsigned cur_slot;
  logic        cur_valid;
  logic [15:0] id_counter;
  logic        halt_flag;

  sched_result_t expected_results[$];

  function automatic int unsigned next_occupied();
    int unsigned idx;
    if (!cur_valid) begin
      for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
        if (task_id[k] != 0) return k;
      end
      return SLOT_COUNT;
    end
    for (int unsigned n = 1; n < SLOT_COUNT; n++) begin
      idx = (cur_slot + n) % SLOT_COUNT;
      if (task_id[idx] != 0) return idx;
    end
    return SLOT_COUNT;
  endfunction

  function automatic sched_result_t schedule_step(wrr_pkg::cmd_e cmd, logic [7:0] prio);
    sched_result_t r;
    int unsigned   free_idx;
    int unsigned   nx;
    logic          run;
    r = '0;
    free_idx = SLOT_COUNT;
    case (cmd)
      wrr_pkg::CMD_CREATE: begin
        for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
          if (task_id[k] == 0 && free_idx == SLOT_COUNT) free_idx = k;
        end
        if (free_idx < SLOT_COUNT) begin
          task_id[free_idx] = id_counter;
          task_prio[free_idx] = prio;
          slice_left[free_idx] = prio;
          started[free_idx] = 1'b0;
          r.created_id = id_counter;
          r.created_slot = free_idx[6:0];
          id_counter = id_counter + 16'd1;
          if (id_counter == 0) id_counter = 16'd1;
        end else begin
          r.table_full = 1'b1;
        end
      end
      wrr_pkg::CMD_TICK: begin
        if (!halt_flag) begin
          if (cur_valid && slice_left[cur_slot] > 0) begin
            slice_left[cur_slot] = slice_left[cur_slot] - 8'd1;
          end else begin
            nx = next_occupied();
            if (nx < SLOT_COUNT) begin
              if (cur_valid) slice_left[cur_slot] = task_prio[cur_slot];
              r.switched = 1'b1;
              r.first_start = !started[nx];
              started[nx] = 1'b1;
              cur_slot = nx;
              cur_valid = 1'b1;
            end else if (!cur_valid || task_id[cur_slot] == 0) begin
              halt_flag = 1'b1;
            end
          end
        end
      end
      wrr_pkg::CMD_EXIT: begin
        if (cur_valid && !halt_flag) begin
          task_id[cur_slot] = '0;
          slice_left[cur_slot] = '0;
        end
      end
      default: ;
    endcase
    run = cur_valid && !halt_flag && task_id[cur_slot] != 0;
    r.run_slot = run ? cur_slot[6:0] : 7'd0;
    r.run_valid = run;
    r.halted = halt_flag;
    return r;
  endfunction

  function automatic int count_occupied();
    int c;
    c = 0;
    for (int unsigned k = 0; k < SLOT_COUNT; k++) if (task_id[k] != 0) c++;
    return c;
  endfunction

  sched_result_t actual;
  assign actual = '{created_id_o, created_slot_o, table_full_o, run_slot_o,
                    run_valid_o, switched_o, first_start_o, halted_o};
  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
        task_id[k] = '0;
        task_prio[k] = '0;
        slice_left[k] = '0;
        started[k] = 1'b0;
      end
      cur_slot = 0;
      cur_valid = 1'b0;
      id_counter = 16'd1;
      halt_flag = 1'b0;
      expected_results.delete();
      fail_count_o = 0;
      result_count_o = 0;
      switch_count_o = 0;
      full_count_o = 0;
      halt_seen_o = 0;
      occupied_o = 0;
    end else begin
      if (valid_i && !stall_o) begin
        expected_results.push_back(schedule_step(wrr_pkg::cmd_e'(command_i),
                                                 priority_req_i));
        occupied_o = count_occupied();
      end
      if (valid_o && !stall_i) begin
        result_count_o++;
        if (switched_o) switch_count_o++;
        if (table_full_o) full_count_o++;
        if (halted_o) halt_seen_o = 1;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("ERROR: unexpected result %h", actual);
        end else begin
          want = expected_results.pop_front();
          if (want !== actual) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("ERROR: result %0d mismatch", result_count_o);
              $display("  expected id=%h slot=%0d full=%b run=%0d/%b sw=%b first=%b halt=%b",
                       want.created_id, want.created_slot, want.table_full,
                       want.run_slot, want.run_valid, want.switched,
                       want.first_start, want.halted);
              $display("  actual   id=%h slot=%0d full=%b run=%0d/%b sw=%b first=%b halt=%b",
                       actual.created_id, actual.created_slot, actual.table_full,
                       actual.run_slot, actual.run_valid, actual.switched,
                       actual.first_start, actual.halted);
            end
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/weighted_round_robin_task_scheduler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_task_scheduler_test
// Drives commands into the task scheduler with random gaps and stalls,
// including table-full, halt and back-pressure phases; the checker compares.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_scheduler_test;

  localparam int unsigned SLOT_COUNT = 128;
  localparam int unsigned RandomItems = 810;
  localparam longint CycleLimit = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  command_i = wrr_pkg::CMD_NOP;
  logic [7:0]  priority_req_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [15:0] created_id_o;
  logic [6:0]  created_slot_o;
  logic        table_full_o;
  logic [6:0]  run_slot_o;
  logic        run_valid_o;
  logic        switched_o;
  logic        first_start_o;
  logic        halted_o;

  int     fail_count, pending, result_count, switch_count, full_count;
  int     halt_seen, occupied;
  int     sent_count = 0;
  bit     hold_off = 1'b0;
  longint cycle_count = 0;

  always #5 clk_i = ~clk_i;

  weighted_round_robin_task_scheduler #(.SLOT_COUNT(SLOT_COUNT)) u_top (.*);

  wrr_sched_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
    .*,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .result_count_o(result_count),
    .switch_count_o(switch_count),
    .full_count_o  (full_count),
    .halt_seen_o   (halt_seen),
    .occupied_o    (occupied)
  );

  // Receiver: random stall per result, long hold-off on request.
  initial begin
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(valid_o && !stall_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_command(wrr_pkg::cmd_e cmd, logic [7:0] prio, bit no_gap = 1'b0);
    int unsigned gap;
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  wrr_pkg::cmd_e pick;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: exit and no-op on an empty table are ignored, then three creates and first ticks.
    send_command(wrr_pkg::CMD_EXIT, 8'h00);
    send_command(wrr_pkg::CMD_NOP, 8'hff);
    send_command(wrr_pkg::CMD_CREATE, 8'h00);
    send_command(wrr_pkg::CMD_CREATE, 8'hff);
    send_command(wrr_pkg::CMD_CREATE, 8'h01);
    send_command(wrr_pkg::CMD_TICK, 8'h00);
    send_command(wrr_pkg::CMD_TICK, 8'h00);
    send_command(wrr_pkg::CMD_TICK, 8'h55);

    // Fill the table past full; receiver holds off so the input backs up.
    hold_off = 1'b1;
    for (int k = 0; k < SLOT_COUNT; k++) send_command(wrr_pkg::CMD_CREATE, 8'(k), 1'b1);
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    pick = wrr_pkg::CMD_CREATE;
        2, 3, 4, 5, 6: pick = wrr_pkg::CMD_TICK;
        7, 8:    pick = wrr_pkg::CMD_EXIT;
        default: pick = wrr_pkg::CMD_NOP;
      endcase
      if (occupied > 100 && pick == wrr_pkg::CMD_CREATE) pick = wrr_pkg::CMD_EXIT;
      send_command(pick, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 3)));
      if (n == RandomItems / 2) drain_results();
    end
    drain_results();

    // Retire every task, then a tick with nothing left halts the block for good.
    for (int k = 0; k < 2 * SLOT_COUNT && occupied > 0; k++) begin
      send_command(wrr_pkg::CMD_EXIT, 8'h00);
      send_command(wrr_pkg::CMD_TICK, 8'h00);
    end
    send_command(wrr_pkg::CMD_TICK, 8'h00);
    send_command(wrr_pkg::CMD_CREATE, 8'h07);
    send_command(wrr_pkg::CMD_TICK, 8'h00);
    send_command(wrr_pkg::CMD_EXIT, 8'haa);
    send_command(wrr_pkg::CMD_NOP, 8'h55);

    drain_results();
    repeat (SLOT_COUNT + 20) @(posedge clk_i);
    $display("Sent %0d commands, checked %0d results: %0d switches, %0d table-full, halt %0s",
             sent_count, result_count, switch_count, full_count,
             halt_seen ? "reached" : "not reached");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wrr_pkg.sv
rtl/core/wrr_front.sv
rtl/core/wrr_back.sv
rtl/core/weighted_round_robin_task_scheduler.sv
tb/sv/wrr_sched_checker.sv
tb/sv/weighted_round_robin_task_scheduler_test.sv
